/* rtl/core/scsp_pkg.sv */
// shared types and constants for the s-curve step pulse sequencer
// no dependencies
package scsp_pkg;

  localparam int TMR_W  = 24;  // timer frequency register
  localparam int SPD_W  = 20;  // speed fields and cruise speed
  localparam int LEN_W  = 11;  // ramp lengths and table pointer
  localparam int IDX_W  = 10;  // table index field
  localparam int HALF_W = 16;  // half period and compare value
  localparam int POS_W  = 32;  // step counts and positions

  localparam logic [LEN_W-1:0]  PTR_MAX  = '1;
  localparam logic [HALF_W-1:0] HALF_SAT = '1;

  typedef enum logic [1:0] {
    CMD_LOAD_ACCEL = 2'd0,
    CMD_LOAD_DECEL = 2'd1,
    CMD_START      = 2'd2,
    CMD_EVENT      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_TIMER_FREQ   = 2'd0,
    REG_CRUISE_SPEED = 2'd1,
    REG_ACCEL_LEN    = 2'd2,
    REG_DECEL_LEN    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    RUN_IDLE   = 3'd0,
    RUN_ACCEL  = 3'd1,
    RUN_CRUISE = 3'd2,
    RUN_DECEL  = 3'd3,
    RUN_STOP   = 3'd4
  } run_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_TBL,
    SEQ_DIV,
    SEQ_OUT
  } seq_t;

  typedef enum logic [1:0] {
    SRC_ACCEL,
    SRC_DECEL,
    SRC_CRUISE
  } src_t;

endpackage

/* rtl/core/scsp_ram.sv */
// generic single write port ram with registered read
// no dependencies
module scsp_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/scsp_div.sv */
// restoring serial divider, one quotient bit per cycle
// depends on scsp_pkg
module scsp_div #(
  parameter int DIV_W = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [scsp_pkg::TMR_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [scsp_pkg::TMR_W-1:0] quotient
);
  import scsp_pkg::*;

  localparam int CNT_W = $clog2(TMR_W + 1);

  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [TMR_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r[DIV_W-1:0], quo_r[TMR_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(TMR_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_nxt = {quo_r[TMR_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/core/s_curve_step_pulse_sequencer_top.sv */
// top level of the s-curve step pulse sequencer: command sequencer and move state
// depends on scsp_pkg, scsp_ram, scsp_div
//
// Usage: each input transfer carries one command. Load commands write one entry
// of the accel or decel speed table, start begins a signed move, and an event
// reports a compare match together with the free-running timer value. Every
// accepted command returns exactly one result transfer holding the next compare
// value, the pin flags, the motor state, the step position and a reject flag.
// Loads and events that need no new period pass from the execute state straight
// to the output state. A start that is not rejected, or a step completed while
// accelerating, cruising or decelerating, reads a ramp table (or the cruise
// speed) and runs the serial divider, one quotient bit per cycle over the
// 24-bit timer frequency, before the result reaches the output state.
// One command is in flight at a time; in_ready is high only while the
// sequencer is idle and out of reset. A finished result sits in an output
// register, so the next command is accepted while that result is still waiting;
// a stalled receiver holds the next result back until the register frees.
// Reset (synchronous, rst_n low) clears the move state, the pin flags and
// restores the configuration defaults; table contents are not cleared and
// must be loaded before use. Configuration is written through cfg_we.
module s_curve_step_pulse_sequencer_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SPEED_BITS  = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [scsp_pkg::TMR_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  logic [scsp_pkg::IDX_W-1:0]    in_index,
  input  logic [scsp_pkg::SPD_W-1:0]    in_speed,
  input  logic signed [scsp_pkg::POS_W-1:0] in_step_count,
  input  logic [scsp_pkg::HALF_W-1:0]   in_timer_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scsp_pkg::HALF_W-1:0]   out_compare_value,
  output logic                          out_step_done,
  output logic                          out_direction,
  output logic                          out_drive_enable,
  output logic                          out_pulse_output_on,
  output logic                          out_event_enable,
  output logic [2:0]                    out_motor_state,
  output logic signed [scsp_pkg::POS_W-1:0] out_position,
  output logic                          out_rejected
);
  import scsp_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = SPEED_BITS;
  localparam int DW = (SPEED_BITS > SPD_W) ? SPEED_BITS : SPD_W;

  function automatic logic sge(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
    return $signed(a) >= $signed(b);
  endfunction

  // configuration
  logic [TMR_W-1:0] tfreq_r;
  logic [SPD_W-1:0] cruise_r;
  logic [LEN_W-1:0] alen_r, dlen_r;

  // sequencer and latched command
  seq_t              seq_r, seq_nxt;
  cmd_t              cmd_r;
  logic [HALF_W-1:0] tim_r;
  logic [POS_W-1:0]  mag_r;
  logic              neg_r;
  src_t              src_r, src_nxt;
  logic              cmp_sum_r, cmp_sum_nxt;
  logic              cmp_half_r, cmp_half_nxt;
  logic              done_r, done_nxt;
  logic              rej_r, rej_nxt;
  logic              dzero_r, dzero_nxt;

  // move state
  run_t              run_r, run_nxt;
  logic [LEN_W-1:0]  ptr_r, ptr_nxt;
  logic              hf_r, hf_nxt;
  logic [POS_W-1:0]  prog_r, prog_nxt;
  logic [POS_W-1:0]  total_r, total_nxt;
  logic [POS_W-1:0]  dstart_r, dstart_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [HALF_W-1:0] half_r, half_nxt;
  logic              pdir_r, pdir_nxt;
  logic              pen_r, pen_nxt;
  logic              ppulse_r, ppulse_nxt;
  logic              pevt_r, pevt_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [HALF_W-1:0] out_cmp_r;
  logic              out_done_r, out_dir_r, out_en_r, out_pulse_r, out_evt_r, out_rej_r;
  logic [2:0]        out_state_r;
  logic [POS_W-1:0]  out_pos_r;

  // table access
  logic              in_fire;
  logic              idx_ok;
  logic [POS_W-1:0]  idx_ext;
  logic [AW-1:0]     waddr;
  logic [SW-1:0]     wdata;
  logic              we_accel, we_decel;
  logic              is_start;
  logic [LEN_W-1:0]  tbl_len, tbl_ptr;
  logic [POS_W-1:0]  n_w, i_w;
  logic [AW-1:0]     raddr;
  logic [SW-1:0]     accel_rd, decel_rd;

  // divider
  logic              div_start;
  logic [DW-1:0]     div_dvs;
  logic              div_done;
  logic [TMR_W-1:0]  div_quo;
  logic [HALF_W-1:0] half_calc;

  // scratch for the step update
  logic [POS_W-1:0]  prog1;
  logic [POS_W-1:0]  ramp_sum;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = rst_n && (seq_r == SEQ_IDLE);
  assign idx_ext  = POS_W'(in_index);
  assign idx_ok   = idx_ext < POS_W'(TABLE_DEPTH);
  assign waddr    = idx_ext[AW-1:0];
  assign wdata    = SW'(in_speed);
  assign we_accel = in_fire && (cmd_t'(in_command) == CMD_LOAD_ACCEL) && idx_ok;
  assign we_decel = in_fire && (cmd_t'(in_command) == CMD_LOAD_DECEL) && idx_ok;

  // read index clamped to the last entry of the ramp
  assign is_start = (cmd_r == CMD_START);
  assign tbl_len  = (!is_start && run_r == RUN_DECEL) ? dlen_r : alen_r;
  assign tbl_ptr  = is_start ? '0 : ptr_r;
  assign n_w      = (POS_W'(tbl_len) < POS_W'(TABLE_DEPTH)) ? POS_W'(tbl_len)
                                                             : POS_W'(TABLE_DEPTH);
  assign i_w      = (n_w == '0) ? '0 :
                    ((POS_W'(tbl_ptr) > n_w - POS_W'(1)) ? n_w - POS_W'(1)
                                                          : POS_W'(tbl_ptr));
  assign raddr    = i_w[AW-1:0];

  scsp_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_accel_ram (
    .clk   (clk),
    .we    (we_accel),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (accel_rd)
  );

  scsp_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_decel_ram (
    .clk   (clk),
    .we    (we_decel),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (decel_rd)
  );

  always_comb begin
    case (src_r)
      SRC_ACCEL: div_dvs = DW'(accel_rd);
      SRC_DECEL: div_dvs = DW'(decel_rd);
      default:   div_dvs = DW'(cruise_r);
    endcase
  end

  assign div_start = (seq_r == SEQ_TBL);

  scsp_div #(.DIV_W(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tfreq_r),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // halve the quotient and saturate; zero speed saturates too
  assign half_calc = (dzero_r || (|div_quo[TMR_W-1:HALF_W+1])) ? HALF_SAT
                                                              : div_quo[HALF_W:1];

  assign ramp_sum = POS_W'(alen_r) + POS_W'(dlen_r);
  assign prog1    = (run_r != RUN_IDLE && run_r != RUN_STOP) ? prog_r + POS_W'(1) : prog_r;
  assign out_load = (seq_r == SEQ_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    seq_nxt      = seq_r;
    src_nxt      = src_r;
    cmp_sum_nxt  = cmp_sum_r;
    cmp_half_nxt = cmp_half_r;
    done_nxt     = done_r;
    rej_nxt      = rej_r;
    dzero_nxt    = dzero_r;
    run_nxt      = run_r;
    ptr_nxt      = ptr_r;
    hf_nxt       = hf_r;
    prog_nxt     = prog_r;
    total_nxt    = total_r;
    dstart_nxt   = dstart_r;
    pos_nxt      = pos_r;
    half_nxt     = half_r;
    pdir_nxt     = pdir_r;
    pen_nxt      = pen_r;
    ppulse_nxt   = ppulse_r;
    pevt_nxt     = pevt_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (seq_r)
      SEQ_IDLE: begin
        if (in_fire) begin
          seq_nxt = SEQ_EXEC;
        end
      end

      SEQ_EXEC: begin
        logic need_div;
        need_div     = 1'b0;
        cmp_sum_nxt  = 1'b0;
        cmp_half_nxt = 1'b0;
        done_nxt     = 1'b0;
        rej_nxt      = 1'b0;
        case (cmd_r)
          CMD_START: begin
            pen_nxt  = 1'b1;
            pdir_nxt = neg_r;
            if (sge(mag_r, ramp_sum)) begin
              total_nxt    = mag_r;
              dstart_nxt   = mag_r - POS_W'(dlen_r);
              prog_nxt     = '0;
              run_nxt      = RUN_ACCEL;
              ptr_nxt      = LEN_W'(1);
              pevt_nxt     = 1'b1;
              src_nxt      = SRC_ACCEL;
              need_div     = 1'b1;
              cmp_half_nxt = 1'b1;
            end else begin
              rej_nxt = 1'b1;
            end
          end
          CMD_EVENT: begin
            if (pevt_r) begin
              hf_nxt      = !hf_r;
              cmp_sum_nxt = 1'b1;
              // second half of the pulse completes a step
              if (hf_r) begin
                done_nxt = 1'b1;
                pos_nxt  = pos_r + POS_W'(1);
                prog_nxt = prog1;
                case (run_r)
                  RUN_ACCEL: begin
                    ppulse_nxt = 1'b1;
                    src_nxt    = SRC_ACCEL;
                    need_div   = 1'b1;
                    if (ptr_r != PTR_MAX) ptr_nxt = ptr_r + LEN_W'(1);
                    if (sge(prog1, POS_W'(alen_r))) run_nxt = RUN_CRUISE;
                  end
                  RUN_DECEL: begin
                    src_nxt  = SRC_DECEL;
                    need_div = 1'b1;
                    if (ptr_r != PTR_MAX) ptr_nxt = ptr_r + LEN_W'(1);
                    if (sge(prog1, total_r)) run_nxt = RUN_STOP;
                  end
                  RUN_CRUISE: begin
                    src_nxt  = SRC_CRUISE;
                    need_div = 1'b1;
                    if (sge(prog1, dstart_r)) begin
                      ptr_nxt = '0;
                      run_nxt = RUN_DECEL;
                    end
                  end
                  RUN_STOP: begin
                    pevt_nxt   = 1'b0;
                    ppulse_nxt = 1'b0;
                    run_nxt    = RUN_IDLE;
                  end
                  default: begin
                    pevt_nxt = 1'b0;
                  end
                endcase
                if (sge(prog1, total_r)) run_nxt = RUN_STOP;
              end
            end
          end
          default: begin
          end
        endcase
        seq_nxt = need_div ? SEQ_TBL : SEQ_OUT;
      end

      SEQ_TBL: begin
        dzero_nxt = (div_dvs == '0);
        seq_nxt   = SEQ_DIV;
      end

      SEQ_DIV: begin
        if (div_done) begin
          half_nxt = half_calc;
          seq_nxt  = SEQ_OUT;
        end
      end

      SEQ_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          seq_nxt       = SEQ_IDLE;
        end
      end

      default: begin
        seq_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tfreq_r     <= TMR_W'(1000000);
      cruise_r    <= SPD_W'(1000);
      alen_r      <= '0;
      dlen_r      <= '0;
      seq_r       <= SEQ_IDLE;
      out_valid_r <= 1'b0;
      run_r       <= RUN_IDLE;
      ptr_r       <= '0;
      hf_r        <= 1'b0;
      prog_r      <= '0;
      total_r     <= '0;
      dstart_r    <= '0;
      pos_r       <= '0;
      half_r      <= '0;
      pdir_r      <= 1'b0;
      pen_r       <= 1'b0;
      ppulse_r    <= 1'b0;
      pevt_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TIMER_FREQ:   tfreq_r  <= cfg_wdata;
          REG_CRUISE_SPEED: cruise_r <= cfg_wdata[SPD_W-1:0];
          REG_ACCEL_LEN:    alen_r   <= cfg_wdata[LEN_W-1:0];
          REG_DECEL_LEN:    dlen_r   <= cfg_wdata[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
      ptr_r       <= ptr_nxt;
      hf_r        <= hf_nxt;
      prog_r      <= prog_nxt;
      total_r     <= total_nxt;
      dstart_r    <= dstart_nxt;
      pos_r       <= pos_nxt;
      half_r      <= half_nxt;
      pdir_r      <= pdir_nxt;
      pen_r       <= pen_nxt;
      ppulse_r    <= ppulse_nxt;
      pevt_r      <= pevt_nxt;
    end
  end

  // command payload and per-item scratch
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_t'(in_command);
      tim_r <= in_timer_count;
      neg_r <= in_step_count[POS_W-1];
      mag_r <= in_step_count[POS_W-1] ? (POS_W'(0) - POS_W'(in_step_count))
                                      : POS_W'(in_step_count);
    end
    src_r      <= src_nxt;
    cmp_sum_r  <= cmp_sum_nxt;
    cmp_half_r <= cmp_half_nxt;
    done_r     <= done_nxt;
    rej_r      <= rej_nxt;
    dzero_r    <= dzero_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmp_sum_r) begin
        out_cmp_r <= tim_r + half_r;
      end else if (cmp_half_r) begin
        out_cmp_r <= half_r;
      end else begin
        out_cmp_r <= '0;
      end
      out_done_r  <= done_r;
      out_dir_r   <= pdir_r;
      out_en_r    <= pen_r;
      out_pulse_r <= ppulse_r;
      out_evt_r   <= pevt_r;
      out_state_r <= run_r;
      out_pos_r   <= pos_r;
      out_rej_r   <= rej_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_compare_value   = out_cmp_r;
  assign out_step_done       = out_done_r;
  assign out_direction       = out_dir_r;
  assign out_drive_enable    = out_en_r;
  assign out_pulse_output_on = out_pulse_r;
  assign out_event_enable    = out_evt_r;
  assign out_motor_state     = out_state_r;
  assign out_position        = $signed(out_pos_r);
  assign out_rejected        = out_rej_r;

endmodule
